// ----- hw/rtl/mbet_pkg.sv -----
`default_nettype none
package mbet_pkg;

	localparam int MAX_ITER   = 64;
	localparam int FRAC_BITS  = 13;
	localparam int COORD_W    = 17;
	localparam int SIDE_W     = 11;
	localparam int PIX_W      = 10;
	localparam int STEP_W     = COORD_W + 1;
	localparam int DVD_W      = COORD_W;
	localparam int DIV_STEPS  = DVD_W;
	localparam int DSTEP_W    = $clog2(DIV_STEPS);
	localparam int ZW         = 30;
	localparam int PW         = 2 * ZW;
	localparam int CNT_W      = $clog2(MAX_ITER + 1);
	localparam int ESC_LIMIT  = 4 << FRAC_BITS;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic        [SIDE_W-1:0]  side_t;
	typedef logic signed [STEP_W-1:0]  step_t;
	typedef logic signed [ZW-1:0]      z_t;
	typedef logic signed [PW-1:0]      prod_t;
	typedef logic        [CNT_W-1:0]   count_t;
	typedef logic        [PIX_W-1:0]   pix_t;
	typedef logic        [2:0]         reg_idx_t;

	localparam reg_idx_t REG_REAL_MIN = 3'd0;
	localparam reg_idx_t REG_REAL_MAX = 3'd1;
	localparam reg_idx_t REG_IMAG_MIN = 3'd2;
	localparam reg_idx_t REG_IMAG_MAX = 3'd3;
	localparam reg_idx_t REG_WIDTH    = 3'd4;
	localparam reg_idx_t REG_HEIGHT   = 3'd5;

	localparam coord_t RST_REAL_MIN = -17'sd10650;
	localparam coord_t RST_REAL_MAX = -17'sd10158;
	localparam coord_t RST_IMAG_MIN = -17'sd245;
	localparam coord_t RST_IMAG_MAX = 17'sd819;
	localparam side_t  RST_WIDTH    = 11'd64;
	localparam side_t  RST_HEIGHT   = 11'd64;

	typedef struct packed {
		coord_t real_min;
		coord_t real_max;
		coord_t imag_min;
		coord_t imag_max;
		side_t  width;
		side_t  height;
	} cfg_t;

	typedef struct packed {
		logic cap;
		logic div_init;
		logic div_step;
		logic div_store;
		logic div_axis;
		logic c_mul;
		logic c_add;
		logic it_mul;
		logic it_upd;
		logic res_load;
	} dp_cmd_t;

	typedef struct packed {
		logic esc;
		logic at_max;
	} dp_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mbet_regs.sv -----
`default_nettype none
module mbet_regs (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       psel,
	input  wire                       penable,
	input  wire                       pwrite,
	input  wire [mbet_pkg::ADDR_W-1:0] paddr,
	input  wire [mbet_pkg::DATA_W-1:0] pwdata,
	output logic [mbet_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output mbet_pkg::cfg_t            cfg,
	output logic                      cfg_wr
);
	import mbet_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = paddr[ADDR_W-1:2];
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.real_min <= RST_REAL_MIN;
			cfg_q.real_max <= RST_REAL_MAX;
			cfg_q.imag_min <= RST_IMAG_MIN;
			cfg_q.imag_max <= RST_IMAG_MAX;
			cfg_q.width    <= RST_WIDTH;
			cfg_q.height   <= RST_HEIGHT;
		end else if (cfg_wr) begin
			unique case (idx)
				REG_REAL_MIN: cfg_q.real_min <= coord_t'(pwdata[COORD_W-1:0]);
				REG_REAL_MAX: cfg_q.real_max <= coord_t'(pwdata[COORD_W-1:0]);
				REG_IMAG_MIN: cfg_q.imag_min <= coord_t'(pwdata[COORD_W-1:0]);
				REG_IMAG_MAX: cfg_q.imag_max <= coord_t'(pwdata[COORD_W-1:0]);
				REG_WIDTH:    cfg_q.width    <= pwdata[SIDE_W-1:0];
				REG_HEIGHT:   cfg_q.height   <= pwdata[SIDE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_REAL_MIN: prdata = DATA_W'(cfg_q.real_min);
			REG_REAL_MAX: prdata = DATA_W'(cfg_q.real_max);
			REG_IMAG_MIN: prdata = DATA_W'(cfg_q.imag_min);
			REG_IMAG_MAX: prdata = DATA_W'(cfg_q.imag_max);
			REG_WIDTH:    prdata = DATA_W'(cfg_q.width);
			REG_HEIGHT:   prdata = DATA_W'(cfg_q.height);
			default:      prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/mbet_datapath.sv -----
`default_nettype none
module mbet_datapath (
	input  wire                        clk,
	input  wire [mbet_pkg::PIX_W-1:0]  col,
	input  wire [mbet_pkg::PIX_W-1:0]  row,
	input  mbet_pkg::cfg_t             cfg,
	input  mbet_pkg::dp_cmd_t          cmd,
	output mbet_pkg::dp_sts_t          sts,
	output logic [mbet_pkg::CNT_W-1:0] escape_count
);
	import mbet_pkg::*;

	pix_t              col_q, row_q;
	step_t             dr_q, di_q;
	logic              neg_q;
	logic [DVD_W-1:0]  dvd_q;
	side_t             dsr_q;
	side_t             rem_q;
	z_t                zr_q, zi_q, cr_q, ci_q;
	prod_t             pr_q, pi_q, px_q;
	count_t            cnt_q, res_q;

	step_t             span_r, span_i, span_sel;
	side_t             side_sel;
	logic [DVD_W-1:0]  span_mag;
	logic [SIDE_W:0]   trial, diff;
	logic              ge;
	step_t             quo_abs, quo;
	prod_t             rq, iq, sum, xs;
	logic              esc;

	assign span_r   = step_t'(cfg.real_max) - step_t'(cfg.real_min);
	assign span_i   = step_t'(cfg.imag_max) - step_t'(cfg.imag_min);
	assign span_sel = cmd.div_axis ? span_i : span_r;
	assign side_sel = cmd.div_axis ? cfg.height : cfg.width;
	assign span_mag = span_sel[STEP_W-1] ? DVD_W'(-span_sel) : DVD_W'(span_sel);

	assign trial   = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = trial >= {1'b0, dsr_q};
	assign diff    = trial - {1'b0, dsr_q};
	assign quo_abs = step_t'({1'b0, dvd_q});
	assign quo     = (dsr_q == '0) ? '0 : (neg_q ? -quo_abs : quo_abs);

	assign rq  = pr_q >>> FRAC_BITS;
	assign iq  = pi_q >>> FRAC_BITS;
	assign sum = rq + iq;
	assign esc = sum > prod_t'(ESC_LIMIT);
	assign xs  = px_q >>> (FRAC_BITS - 1);

	assign sts.esc      = esc;
	assign sts.at_max   = cnt_q == count_t'(MAX_ITER);
	assign escape_count = res_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			col_q <= col;
			row_q <= row;
		end
		if (cmd.div_init) begin
			neg_q <= span_sel[STEP_W-1];
			dvd_q <= span_mag;
			dsr_q <= side_sel;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[SIDE_W-1:0] : trial[SIDE_W-1:0];
		end
		if (cmd.div_store) begin
			if (cmd.div_axis) begin
				di_q <= quo;
			end else begin
				dr_q <= quo;
			end
		end
		if (cmd.c_mul) begin
			pr_q <= $signed({1'b0, col_q}) * dr_q;
			pi_q <= $signed({1'b0, row_q}) * di_q;
		end else if (cmd.it_mul) begin
			pr_q <= zr_q * zr_q;
			pi_q <= zi_q * zi_q;
			px_q <= zr_q * zi_q;
		end
		if (cmd.c_add) begin
			cr_q  <= z_t'(cfg.real_min) + z_t'(pr_q[ZW-1:0]);
			zr_q  <= z_t'(cfg.real_min) + z_t'(pr_q[ZW-1:0]);
			ci_q  <= z_t'(cfg.imag_max) - z_t'(pi_q[ZW-1:0]);
			zi_q  <= z_t'(cfg.imag_max) - z_t'(pi_q[ZW-1:0]);
			cnt_q <= '0;
		end else if (cmd.it_upd) begin
			zi_q  <= z_t'(xs[ZW-1:0]) + ci_q;
			zr_q  <= z_t'(rq[ZW-1:0]) - z_t'(iq[ZW-1:0]) + cr_q;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.res_load) begin
			res_q <= cnt_q;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/mbet_ctrl.sv -----
`default_nettype none
module mbet_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire                out_stall,
	input  wire                cfg_wr,
	input  mbet_pkg::dp_sts_t  sts,
	output mbet_pkg::dp_cmd_t  cmd
);
	import mbet_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DINIT,
		S_DSTEP,
		S_DSTORE,
		S_CMUL,
		S_CADD,
		S_MUL,
		S_UPD,
		S_FIN
	} state_t;

	typedef logic [DSTEP_W-1:0] dstep_t;

	state_t state_q;
	logic   axis_q;
	logic   dirty_q;
	logic   out_valid_q;
	dstep_t step_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.cap      = (state_q == S_IDLE) && in_valid;
		cmd.div_axis = axis_q;
		unique case (state_q)
			S_IDLE:   ;
			S_DINIT:  cmd.div_init  = 1'b1;
			S_DSTEP:  cmd.div_step  = 1'b1;
			S_DSTORE: cmd.div_store = 1'b1;
			S_CMUL:   cmd.c_mul     = 1'b1;
			S_CADD:   cmd.c_add     = 1'b1;
			S_MUL:    cmd.it_mul    = !sts.at_max;
			S_UPD:    cmd.it_upd    = !sts.esc;
			S_FIN:    cmd.res_load  = slot_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 1'b0;
			dirty_q     <= 1'b1;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (state_q == S_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						axis_q  <= 1'b0;
						state_q <= dirty_q ? S_DINIT : S_CMUL;
					end
				end
				S_DINIT: begin
					step_q  <= '0;
					state_q <= S_DSTEP;
				end
				S_DSTEP: begin
					step_q <= step_q + 1'b1;
					if (step_q == dstep_t'(DIV_STEPS - 1)) begin
						state_q <= S_DSTORE;
					end
				end
				S_DSTORE: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= S_DINIT;
					end else begin
						state_q <= S_CMUL;
					end
				end
				S_CMUL: state_q <= S_CADD;
				S_CADD: state_q <= S_MUL;
				S_MUL:  state_q <= sts.at_max ? S_FIN : S_UPD;
				S_UPD:  state_q <= sts.esc ? S_FIN : S_MUL;
				S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_wr) begin
				dirty_q <= 1'b1;
			end else if (state_q == S_DSTORE && axis_q) begin
				dirty_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DINIT || state_q == S_CMUL))
		else $error("request accepted but no computation started");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over an untaken result");

	a_esc_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && sts.esc) |=> (state_q == S_FIN))
		else $error("escape did not end the iteration");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DSTEP) |-> (step_q <= dstep_t'(DIV_STEPS - 1)))
		else $error("divide step counter overran");

	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && slot_free) |=> out_valid)
		else $error("finished result not presented");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/mandelbrot_escape_time_pixel.sv -----
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_stall   col[9:0], row[9:0]
// result    out        out_valid / out_stall escape_count[6:0]
// config    APB        psel/penable/pwrite   paddr[4:0], pwdata/prdata[31:0]
//
// A request is taken only in the idle state, so one pixel is computed at a time; a new
// request is accepted only once the previous count has gone to the output register.
// Each escape round runs a multiply step and then an update step.
// The first request after reset or after any register write first runs two
// 17-step restoring divides that form the column and row steps.
// A finished result waits in the output register; the next request is taken meanwhile.
// Reset loads the register defaults and leaves no result pending.
`default_nettype none
module mandelbrot_escape_time_pixel (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire [mbet_pkg::PIX_W-1:0]   col,
	input  wire [mbet_pkg::PIX_W-1:0]   row,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [mbet_pkg::CNT_W-1:0]  escape_count,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [mbet_pkg::ADDR_W-1:0]  paddr,
	input  wire [mbet_pkg::DATA_W-1:0]  pwdata,
	output logic [mbet_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import mbet_pkg::*;

	cfg_t    cfg;
	logic    cfg_wr;
	dp_cmd_t cmd;
	dp_sts_t sts;

	mbet_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.cfg_wr  (cfg_wr)
	);

	mbet_datapath u_dp (
		.clk          (clk),
		.col          (col),
		.row          (row),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.escape_count (escape_count)
	);

	mbet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_wr    (cfg_wr),
		.sts       (sts),
		.cmd       (cmd)
	);

endmodule
`default_nettype wire

// ----- sim/mandelbrot_escape_time_pixel_tb.sv -----
`default_nettype none
module mandelbrot_escape_time_pixel_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mbet_pkg::*;

	localparam int LIMIT_CYCLES  = 1_200_000;
	localparam int PHASES        = 12;
	localparam int PIX_PER_PHASE = 128;
	localparam int HOLD_CYCLES   = 600;
	localparam int TAIL_CYCLES   = 200;

	localparam reg_idx_t REG_SPARE_LO = 3'd6;
	localparam reg_idx_t REG_SPARE_HI = 3'd7;

	typedef struct packed {
		pix_t col;
		pix_t row;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	pix_t col = '0;
	pix_t row = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	count_t escape_count;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	cfg_t frame;
	pixel_t pending_pixels[$];
	count_t expected_counts[$];
	int mismatches = 0;
	int cycle_count = 0;
	int send_idle_pct = 8;
	int recv_idle_pct = 53;
	logic hold_arm = 1'b0;
	logic hold_spent = 1'b0;
	int hold_left = 0;

	mandelbrot_escape_time_pixel uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.col(col),
		.row(row),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.escape_count(escape_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint axis_step(coord_t hi, coord_t lo, side_t n);
		if (n == '0)
			return 0;
		return (longint'(hi) - longint'(lo)) / longint'(n);
	endfunction

	function automatic count_t escape_count_of(pix_t c, pix_t r);
		longint cr, ci, zr, zi, rq, iq;
		int n;
		cr = longint'(frame.real_min)
			+ longint'(c) * axis_step(frame.real_max, frame.real_min, frame.width);
		ci = longint'(frame.imag_max)
			- longint'(r) * axis_step(frame.imag_max, frame.imag_min, frame.height);
		zr = cr;
		zi = ci;
		for (n = 0; n < MAX_ITER; n++) begin
			rq = (zr * zr) >>> FRAC_BITS;
			iq = (zi * zi) >>> FRAC_BITS;
			if (rq + iq > longint'(ESC_LIMIT))
				break;
			zi = ((zr * zi) >>> (FRAC_BITS - 1)) + ci;
			zr = rq - iq + cr;
		end
		return count_t'(n);
	endfunction

	// driver: when the current request is gone, offer the next pixel or idle at random
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			expected_counts.push_back(escape_count_of(col, row));
		if (!in_valid || !in_stall) begin
			if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				col <= pending_pixels[0].col;
				row <= pending_pixels[0].row;
				pending_pixels.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check each accepted count, stall at random or for a long hold
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_counts.size() == 0) begin
				$display("%0t: unexpected result, escape_count %0d", $time, escape_count);
				mismatches++;
			end else begin
				if (escape_count !== expected_counts[0]) begin
					$display("%0t: escape_count expected %0d got %0d",
						$time, expected_counts[0], escape_count);
					mismatches++;
				end
				expected_counts.pop_front();
			end
		end
		if (hold_left != 0) begin
			hold_left--;
		end else if (hold_arm && !hold_spent) begin
			hold_left = HOLD_CYCLES;
			hold_spent = 1'b1;
		end
		out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_REAL_MIN: frame.real_min = coord_t'(value[COORD_W-1:0]);
			REG_REAL_MAX: frame.real_max = coord_t'(value[COORD_W-1:0]);
			REG_IMAG_MIN: frame.imag_min = coord_t'(value[COORD_W-1:0]);
			REG_IMAG_MAX: frame.imag_max = coord_t'(value[COORD_W-1:0]);
			REG_WIDTH:    frame.width = value[SIDE_W-1:0];
			REG_HEIGHT:   frame.height = value[SIDE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_frame(input int rmin, input int rmax, input int imin, input int imax,
		input int w, input int h);
		reg_write(REG_REAL_MIN, DATA_W'(rmin));
		reg_write(REG_REAL_MAX, DATA_W'(rmax));
		reg_write(REG_IMAG_MIN, DATA_W'(imin));
		reg_write(REG_IMAG_MAX, DATA_W'(imax));
		reg_write(REG_WIDTH, DATA_W'(w));
		reg_write(REG_HEIGHT, DATA_W'(h));
	endtask

	task automatic queue_pixel(input int c, input int r);
		pixel_t px;
		px.col = pix_t'(c);
		px.row = pix_t'(r);
		pending_pixels.push_back(px);
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (pending_pixels.size() != 0 || expected_counts.size() != 0 || in_valid);
	endtask

	task automatic set_idle(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	initial begin
		int w, h, cr, ci, half, cmax, rmax;
		frame.real_min = RST_REAL_MIN;
		frame.real_max = RST_REAL_MAX;
		frame.imag_min = RST_IMAG_MIN;
		frame.imag_max = RST_IMAG_MAX;
		frame.width = RST_WIDTH;
		frame.height = RST_HEIGHT;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		set_idle(8, 53);

		// reset frame, corners and pixels past the frame edge
		queue_pixel(0, 0);
		queue_pixel(63, 63);
		queue_pixel(0, 1023);
		queue_pixel(1023, 0);
		queue_pixel(1023, 1023);
		queue_pixel(31, 40);
		drain();

		// widest edges, one pixel per axis
		load_frame(-65536, 65535, -65536, 65535, 1, 1);
		queue_pixel(0, 0);
		queue_pixel(1, 1);
		queue_pixel(1023, 1023);
		drain();

		// zero width and height: every pixel sits on the edge point
		load_frame(-8192, 8192, -4096, 0, 0, 0);
		queue_pixel(0, 0);
		queue_pixel(1023, 1023);
		queue_pixel(512, 3);
		drain();

		// inverted edges, sides above the nominal maximum
		load_frame(8192, -16384, 9830, -9830, 2047, 2047);
		queue_pixel(0, 0);
		queue_pixel(700, 700);
		queue_pixel(1023, 1023);
		drain();

		// writes to unused addresses leave the frame alone
		load_frame(-16384, 8192, -9830, 9830, 32, 32);
		reg_write(REG_SPARE_LO, '1);
		reg_write(REG_SPARE_HI, '1);
		queue_pixel(16, 16);
		queue_pixel(5, 20);
		queue_pixel(31, 0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES / 3)
				set_idle(53, 8);
			else if (p == 2 * PHASES / 3)
				set_idle(0, 0);
			if (p == 0) begin
				w = 64;
				h = 48;
				load_frame(-16384, 8192, -9830, 9830, w, h);
			end else if (p == PHASES / 3) begin
				w = 1024;
				h = 1024;
				load_frame(-16384, 8192, -9830, 9830, w, h);
			end else begin
				half = (1 << $urandom_range(3, 13)) + $urandom_range(0, 7);
				cr = int'($urandom_range(0, 22937)) - 18022;
				ci = int'($urandom_range(0, 19660)) - 9830;
				w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 96);
				h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 96);
				if ($urandom_range(0, 9) == 0)
					load_frame(cr + half, cr - half, ci + half, ci - half, w, h);
				else
					load_frame(cr - half, cr + half, ci - half, ci + half, w, h);
			end
			if (p == 1)
				hold_arm = 1'b1;
			cmax = (w > 1024) ? 1023 : w - 1;
			rmax = (h > 1024) ? 1023 : h - 1;
			for (int i = 0; i < PIX_PER_PHASE; i++) begin
				if (cmax < 0 || rmax < 0 || $urandom_range(0, 9) == 0)
					queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
				else
					queue_pixel($urandom_range(0, cmax), $urandom_range(0, rmax));
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_counts.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire
